>>> rtl/core/smh_pkg.sv
// Shared types, constants and helper functions of the SHA-256 message hash unit.
`timescale 1ns / 1ps

package smh_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;
  } smh_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } smh_out_t;

  typedef enum logic [1:0] {
    SEL_MSG  = 2'd0,
    SEL_MARK = 2'd1,
    SEL_ZERO = 2'd2,
    SEL_LEN  = 2'd3
  } byte_sel_e;

  typedef struct packed {
    logic      shift_en;
    byte_sel_e sel;
    logic      init_vars;
    logic      round_en;
    logic      add_en;
    logic      finish;
  } smh_cmd_t;

  typedef struct packed {
    logic [6:0] count;
    logic       last_round;
    logic       out_busy;
  } smh_sts_t;

  localparam logic [6:0] LastByte = 7'd63;
  localparam logic [6:0] LenStart = 7'd56;
  localparam logic [7:0] PadMark  = 8'h80;

  localparam logic [255:0] InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

>>> rtl/core/smh_ctrl.sv
// Control state machine that sequences byte loading, padding, rounds and digest output.
`timescale 1ns / 1ps

module smh_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  smh_pkg::smh_in_t in_data_i,
  output logic            in_stall_o,
  input  smh_pkg::smh_sts_t sts_i,
  output smh_pkg::smh_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ROUND = 6'b000010,
    S_ADD   = 6'b000100,
    S_PAD   = 6'b001000,
    S_LEN   = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic              pend_q, pend_d;
  logic              mark_q, mark_d;
  logic              fin_q, fin_d;
  smh_pkg::smh_cmd_t cmd;

  always_comb begin
    cmd     = '0;
    cmd.sel = smh_pkg::SEL_MSG;
    state_d = state_q;
    pend_d  = pend_q;
    mark_d  = mark_q;
    fin_d   = fin_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.byte_present) begin
            cmd.shift_en = 1'b1;
          end
          if (in_data_i.end_of_message) begin
            pend_d = 1'b1;
          end
          if (in_data_i.byte_present && sts_i.count == smh_pkg::LastByte) begin
            cmd.init_vars = 1'b1;
            state_d       = S_ROUND;
          end else if (in_data_i.end_of_message) begin
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (!mark_q) begin
          cmd.shift_en = 1'b1;
          cmd.sel      = smh_pkg::SEL_MARK;
          mark_d       = 1'b1;
        end else if (sts_i.count == smh_pkg::LenStart) begin
          state_d = S_LEN;
        end else begin
          cmd.shift_en = 1'b1;
          cmd.sel      = smh_pkg::SEL_ZERO;
        end
        if (cmd.shift_en && sts_i.count == smh_pkg::LastByte) begin
          cmd.init_vars = 1'b1;
          state_d       = S_ROUND;
        end
      end
      S_LEN: begin
        cmd.shift_en = 1'b1;
        cmd.sel      = smh_pkg::SEL_LEN;
        if (sts_i.count == smh_pkg::LastByte) begin
          cmd.init_vars = 1'b1;
          fin_d         = 1'b1;
          state_d       = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        if (sts_i.last_round) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add_en = 1'b1;
        if (fin_q) begin
          state_d = S_DONE;
        end else if (pend_q) begin
          state_d = S_PAD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd.finish = 1'b1;
          pend_d     = 1'b0;
          mark_d     = 1'b0;
          fin_d      = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
      mark_q  <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      mark_q  <= mark_d;
      fin_q   <= fin_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign cmd_o      = cmd;

  a_finish_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> !sts_i.out_busy)
    else $error("Digest loaded while the output register still holds beats.");

  a_round_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND || state_q == S_ADD) |-> sts_i.count == 7'd0)
    else $error("Byte count is not cleared during compression.");

  a_len_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LEN) |-> sts_i.count >= smh_pkg::LenStart)
    else $error("Length bytes placed outside the last eight block bytes.");

  a_fin_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> (mark_q && pend_q))
    else $error("Final block started without the padding mark.");

endmodule

>>> rtl/core/smh_datapath.sv
// Datapath: block shift register, message schedule, round logic, hash state and digest output.
`timescale 1ns / 1ps

module smh_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  smh_pkg::smh_in_t  in_data_i,
  input  smh_pkg::smh_cmd_t cmd_i,
  output smh_pkg::smh_sts_t sts_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output smh_pkg::smh_out_t out_data_o
);

  logic [511:0]      blk_q, blk_d;
  logic [6:0]        cnt_q, cnt_d;
  logic [63:0]       bits_q, bits_d;
  logic [5:0]        round_q, round_d;
  logic [0:7][31:0]  vars_q, vars_d;
  logic [0:7][31:0]  hash_q, hash_d;
  logic [255:0]      dig_q, dig_d;
  logic [3:0]        left_q, left_d;
  logic [2:0]        idx_q, idx_d;
  logic [7:0]        in_byte;
  logic [31:0]       w_cur, w_new, t1, t2;
  logic              out_take;

  always_comb begin
    case (cmd_i.sel)
      smh_pkg::SEL_MSG:  in_byte = in_data_i.msg_byte;
      smh_pkg::SEL_MARK: in_byte = smh_pkg::PadMark;
      smh_pkg::SEL_ZERO: in_byte = 8'h00;
      smh_pkg::SEL_LEN:  in_byte = bits_q[63 - 8 * cnt_q[2:0] -: 8];
      default:           in_byte = 8'h00;
    endcase
  end

  assign w_cur = blk_q[511:480];
  assign w_new = smh_pkg::small_sigma1(blk_q[511-32*14 -: 32]) + blk_q[511-32*9 -: 32] +
                 smh_pkg::small_sigma0(blk_q[511-32*1 -: 32]) + w_cur;
  assign t1 = vars_q[7] + smh_pkg::big_sigma1(vars_q[4]) +
              ((vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6])) +
              smh_pkg::RoundK[round_q] + w_cur;
  assign t2 = smh_pkg::big_sigma0(vars_q[0]) +
              ((vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]));

  assign out_take = out_valid_o && !out_stall_i;

  always_comb begin
    blk_d   = blk_q;
    cnt_d   = cnt_q;
    bits_d  = bits_q;
    round_d = round_q;
    vars_d  = vars_q;
    hash_d  = hash_q;
    dig_d   = dig_q;
    left_d  = left_q;
    idx_d   = idx_q;
    if (cmd_i.shift_en) begin
      blk_d = {blk_q[503:0], in_byte};
      cnt_d = cnt_q + 7'd1;
      if (cmd_i.sel == smh_pkg::SEL_MSG) begin
        bits_d = bits_q + 64'd8;
      end
    end
    if (cmd_i.init_vars) begin
      cnt_d   = 7'd0;
      round_d = 6'd0;
      vars_d  = hash_q;
    end
    if (cmd_i.round_en) begin
      blk_d   = {blk_q[479:0], w_new};
      round_d = round_q + 6'd1;
      vars_d  = {t1 + t2, vars_q[0], vars_q[1], vars_q[2],
                 vars_q[3] + t1, vars_q[4], vars_q[5], vars_q[6]};
    end
    if (cmd_i.add_en) begin
      for (int i = 0; i < 8; i++) begin
        hash_d[i] = hash_q[i] + vars_q[i];
      end
    end
    if (out_take) begin
      dig_d  = {dig_q[223:0], 32'h0};
      left_d = left_q - 4'd1;
      idx_d  = idx_q + 3'd1;
    end
    if (cmd_i.finish) begin
      dig_d  = hash_q;
      left_d = 4'd8;
      idx_d  = 3'd0;
      hash_d = smh_pkg::InitHash;
      bits_d = 64'd0;
      cnt_d  = 7'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= 7'd0;
      bits_q  <= 64'd0;
      round_q <= 6'd0;
      hash_q  <= smh_pkg::InitHash;
      left_q  <= 4'd0;
      idx_q   <= 3'd0;
    end else begin
      cnt_q   <= cnt_d;
      bits_q  <= bits_d;
      round_q <= round_d;
      hash_q  <= hash_d;
      left_q  <= left_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q  <= blk_d;
    vars_q <= vars_d;
    dig_q  <= dig_d;
  end

  assign out_valid_o            = (left_q != 4'd0);
  assign out_data_o.digest_word = dig_q[255:224];
  assign out_data_o.word_index  = idx_q;
  assign out_data_o.last_word   = (idx_q == 3'd7);

  assign sts_o.count      = cnt_q;
  assign sts_o.last_round = (round_q == 6'd63);
  assign sts_o.out_busy   = out_valid_o;

endmodule

>>> rtl/core/sha256_message_hash_unit.sv
// Top level of the SHA-256 message hash unit.
//
// Input beats carry one optional message byte and an optional end mark. A beat
// is taken when in_valid_i is high and in_stall_o is low; in_stall_o is low
// only while the unit waits for message bytes. The 64th byte of a block
// starts the compression, which runs one round a cycle on a single round
// unit through all 64 rounds and then folds the result into the hash.
// An end mark pads the block one byte a cycle, pausing while a full block is
// compressed and before the length bytes (up to 56 zero bytes, then eight
// length bytes), and compresses one or two more blocks before the digest
// is ready.
// The digest leaves as eight output beats of 32 bits, H0 first, with the word
// index on every beat and a last flag on the eighth. These beats drain from
// their own register, so the next message can stream in while the receiver
// stalls output; a second digest waits until the first has fully drained.
// Reset returns the hash state to its initial values and clears the byte and
// bit counts; any digest not yet delivered is dropped.
`timescale 1ns / 1ps

module sha256_message_hash_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  smh_pkg::smh_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output smh_pkg::smh_out_t out_data_o
);

  smh_pkg::smh_cmd_t cmd;
  smh_pkg::smh_sts_t sts;

  smh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  smh_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
